FILE: rtl/fcls_pkg.sv
package fcls_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned GROUP_SIZE = 4;
    localparam int unsigned GROUP_LOG2 = $clog2(GROUP_SIZE);
    localparam int unsigned SUM_W      = PIX_W + GROUP_LOG2;
    localparam int unsigned SAD_W      = 25;
    localparam int unsigned CNT_W      = 18;
    localparam int unsigned DIM_W      = 12;
    localparam int unsigned BLK_W      = 8;
    localparam int unsigned WHT_W      = 9;
    localparam int unsigned PROD_W     = 2 * DIM_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [DIM_W-1:0] WIDTH_RST = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic [BLK_W-1:0] BLACK_RST = BLK_W'(25);
    localparam logic [WHT_W-1:0] WHITE_RST = WHT_W'(231);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLACK_LEVEL  = 2'd2,
        CFG_WHITE_LEVEL  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
    } t_pixel;

    typedef struct packed {
        logic [SAD_W-1:0] sad_total;
        logic [CNT_W-1:0] black_count;
        logic [CNT_W-1:0] white_count;
        logic [CNT_W-1:0] group_count;
    } t_result;

    // control passed from the pixel stage to the statistics stage
    typedef struct packed {
        logic vld;   // a pixel was taken
        logic grp;   // it closed a group: store read issued
        logic last;  // it ended the frame
        logic emit;  // frame end with a previous frame to compare against
    } t_s0_ctl;

endpackage

FILE: rtl/fcls_stream_if.sv
interface fcls_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/frame_change_and_level_stats.sv
// Frame change and level statistics.
// i_pix (sink): one 8-bit luma pixel per transaction, raster order.
// o_res (source): one transaction per frame end, from the second frame after
//   reset on: SAD against the previous reduced frame, black and white counts
//   of reduced pixels, and the number of reduced pixels (groups).
// Config: i_cfg_we / i_cfg_idx / i_cfg_data, one register per write; write
//   only while no pixel is in flight. i_pix.ready drops for one cycle after
//   each write while the frame length is recomputed.
// Pipeline: pixel stage (group sum, position, store read) -> statistics
//   stage (store data back, SAD and level counts, store write) -> output
//   register. A frame's result is loaded there from the statistics stage.
// Throughput: one pixel per cycle while i_pix.ready is high, set by the single
//   store read every fourth pixel and its write-back from the statistics
//   stage. i_pix.ready drops in the same cycle while o_res is stalled with a
//   result waiting and a further frame end sits in the statistics stage.
// Reset: position, group sum and counts clear; i_pix.ready is low for the
//   first cycle after reset; the store is not cleared, the first frame after
//   reset only fills it and produces no result.
// Stall on o_res: the result holds in the output register; pixels keep
//   flowing until another frame end reaches the statistics stage.
module frame_change_and_level_stats #(
    parameter int unsigned MAX_GROUPS = 131072
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    fcls_stream_if.sink                          i_pix,
    fcls_stream_if.source                        o_res,
    input  logic                                 i_cfg_we,
    input  logic [fcls_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fcls_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_GROUPS);
    localparam int unsigned POS_W = IDX_W + fcls_pkg::GROUP_LOG2;
    localparam int unsigned LEN_W = $clog2(fcls_pkg::GROUP_SIZE * MAX_GROUPS + 1);
    localparam int unsigned GRP_W = LEN_W - fcls_pkg::GROUP_LOG2;
    localparam logic [fcls_pkg::PROD_W-1:0] CAP =
        fcls_pkg::PROD_W'(fcls_pkg::GROUP_SIZE * MAX_GROUPS);

    // configuration
    logic [fcls_pkg::DIM_W-1:0]  r_width;
    logic [fcls_pkg::DIM_W-1:0]  r_height;
    logic [fcls_pkg::BLK_W-1:0]  r_black;
    logic [fcls_pkg::WHT_W-1:0]  r_white;
    logic                        r_cfg_busy;

    // frame length, saturated and never zero
    logic [fcls_pkg::PROD_W-1:0] prod;
    logic [LEN_W-1:0]            n_len, r_len;
    logic [GRP_W-1:0]            r_groups;

    // pixel stage
    logic [POS_W-1:0]            r_pos;
    logic [fcls_pkg::SUM_W-1:0]  r_group_sum;
    logic                        r_have_prev;
    logic [fcls_pkg::SUM_W-1:0]  sum_new;
    logic                        accept;
    logic                        in_range;
    logic                        grp_done;
    logic                        last;
    fcls_pkg::t_s0_ctl           ctl;
    logic                        stats_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= fcls_pkg::WIDTH_RST;
            r_height   <= fcls_pkg::HEIGHT_RST;
            r_black    <= fcls_pkg::BLACK_RST;
            r_white    <= fcls_pkg::WHITE_RST;
            r_cfg_busy <= 1'b1;
        end else begin
            r_cfg_busy <= i_cfg_we;
            if (i_cfg_we) begin
                case (fcls_pkg::t_cfg_idx'(i_cfg_idx))
                    fcls_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    fcls_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    fcls_pkg::CFG_BLACK_LEVEL:  r_black  <= i_cfg_data[fcls_pkg::BLK_W-1:0];
                    fcls_pkg::CFG_WHITE_LEVEL:  r_white  <= i_cfg_data[fcls_pkg::WHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prod = fcls_pkg::PROD_W'(r_width) * fcls_pkg::PROD_W'(r_height);
        if (prod > CAP) begin
            n_len = LEN_W'(CAP);
        end else if (prod == '0) begin
            n_len = LEN_W'(1);
        end else begin
            n_len = LEN_W'(prod);
        end
    end

    // recomputed every cycle; the busy cycle after a write covers the lag
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_groups <= n_len[LEN_W-1:fcls_pkg::GROUP_LOG2];
    end

    assign accept   = i_pix.valid && i_pix.ready;
    assign in_range = GRP_W'(r_pos[POS_W-1:fcls_pkg::GROUP_LOG2]) < r_groups;
    assign grp_done = in_range && (r_pos[fcls_pkg::GROUP_LOG2-1:0] == '1);
    assign last     = (LEN_W'(r_pos) + LEN_W'(1)) >= r_len;
    assign sum_new  = r_group_sum + fcls_pkg::SUM_W'(i_pix.data.luma);

    always_comb begin
        ctl.vld  = accept;
        ctl.grp  = accept && grp_done;
        ctl.last = last;
        ctl.emit = last && r_have_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_group_sum <= '0;
            r_have_prev <= 1'b0;
        end else if (accept) begin
            if (last) begin
                r_pos       <= '0;
                r_group_sum <= '0;
                r_have_prev <= 1'b1;
            end else begin
                r_pos <= r_pos + POS_W'(1);
                if (in_range) begin
                    r_group_sum <= grp_done ? '0 : sum_new;
                end
            end
        end
    end

    assign i_pix.ready = !r_cfg_busy && !stats_busy;

    fcls_stats #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_reduced     (sum_new[fcls_pkg::SUM_W-1:fcls_pkg::GROUP_LOG2]),
        .i_idx         (r_pos[POS_W-1:fcls_pkg::GROUP_LOG2]),
        .i_black_level (r_black),
        .i_white_level (r_white),
        .i_group_count (fcls_pkg::CNT_W'(r_groups)),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_out         (o_res.data),
        .o_busy        (stats_busy)
    );

`ifndef SYNTHESIS
    // store reads never come in consecutive cycles: a group closes only every fourth pixel
    a_read_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.grp |=> !ctl.grp)
        else $error("store read issued in consecutive cycles");

    a_first_frame_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> r_have_prev)
        else $error("result shown before a full frame was stored");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last |=> (r_pos == '0) && (r_group_sum == '0))
        else $error("frame end did not restart position and group sum");
`endif

endmodule

FILE: rtl/fcls_stats.sv
module fcls_stats #(
    parameter int unsigned MAX_GROUPS = 131072
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcls_pkg::t_s0_ctl                   i_ctl,
    input  logic [fcls_pkg::PIX_W-1:0]          i_reduced,
    input  logic [$clog2(MAX_GROUPS)-1:0]       i_idx,
    input  logic [fcls_pkg::BLK_W-1:0]          i_black_level,
    input  logic [fcls_pkg::WHT_W-1:0]          i_white_level,
    input  logic [fcls_pkg::CNT_W-1:0]          i_group_count,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output fcls_pkg::t_result                   o_out,
    output logic                                o_busy
);

    localparam int unsigned IDX_W = $clog2(MAX_GROUPS);

    logic [fcls_pkg::PIX_W-1:0] r_mem [MAX_GROUPS];
    logic [fcls_pkg::PIX_W-1:0] r_prev;

    fcls_pkg::t_s0_ctl          r_ctl;
    logic [fcls_pkg::PIX_W-1:0] r_red;
    logic [IDX_W-1:0]           r_idx;

    logic [fcls_pkg::SAD_W-1:0] r_sad, n_sad;
    logic [fcls_pkg::CNT_W-1:0] r_blk, n_blk;
    logic [fcls_pkg::CNT_W-1:0] r_wht, n_wht;

    logic                       r_out_vld;
    fcls_pkg::t_result          r_out;

    logic                       hold;
    logic                       fire;
    logic [fcls_pkg::PIX_W-1:0] diff;
    logic                       is_blk;
    logic                       is_wht;

    assign hold = r_ctl.vld && r_ctl.emit && r_out_vld && !i_out_ready;
    assign fire = r_ctl.vld && !hold;

    // store: read when a group closes, written back from the statistics stage.
    // Reads of the store are at least four pixels apart, so a write always
    // lands before the next read and no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (i_ctl.grp) begin
            r_prev <= r_mem[i_idx];
        end
        if (fire && r_ctl.grp) begin
            r_mem[r_idx] <= r_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (!hold) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold) begin
            r_red <= i_reduced;
            r_idx <= i_idx;
        end
    end

    always_comb begin
        diff   = (r_red >= r_prev) ? (r_red - r_prev) : (r_prev - r_red);
        is_blk = r_ctl.grp && (r_red <= i_black_level);
        is_wht = r_ctl.grp && ({1'b0, r_red} >= i_white_level);
        n_sad  = r_sad + (r_ctl.grp ? fcls_pkg::SAD_W'(diff) : '0);
        n_blk  = r_blk + fcls_pkg::CNT_W'(is_blk);
        n_wht  = r_wht + fcls_pkg::CNT_W'(is_wht);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sad <= '0;
            r_blk <= '0;
            r_wht <= '0;
        end else if (fire) begin
            if (r_ctl.last) begin
                r_sad <= '0;
                r_blk <= '0;
                r_wht <= '0;
            end else begin
                r_sad <= n_sad;
                r_blk <= n_blk;
                r_wht <= n_wht;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && r_ctl.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_ctl.emit) begin
            r_out.sad_total   <= n_sad;
            r_out.black_count <= n_blk;
            r_out.white_count <= n_wht;
            r_out.group_count <= i_group_count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_busy      = hold;

endmodule
